/* sv/tbr_pkg.sv */
// Shared types and constants for the triangle block rasterizer.
// No dependencies; the controller, datapath, top level and testbench import this package.
`timescale 1ns / 1ps

package tbr_pkg;

    localparam int SCREEN_PIXELS = 1024;
    localparam int BLOCK_SIZE    = 8;
    localparam int SUBPIXEL_BITS = 4;
    localparam int ROUND_UP      = 15;

    localparam int COORD_W = 14;   // 10.4 vertex coordinate
    localparam int POS_W   = 11;   // pixel position, up to SCREEN_PIXELS
    localparam int DELTA_W = 15;   // signed vertex delta
    localparam int MULB_W  = 17;   // signed second multiplier operand
    localparam int PROD_W  = 32;
    localparam int EDGE_W  = 36;   // signed edge function value
    localparam int COLOR_W = 32;
    localparam int MASK_W  = BLOCK_SIZE * BLOCK_SIZE;
    localparam int OUTPOS_W = 10;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEARCH,
        ST_SEARCH_NEXT,
        ST_FINISH
    } state_t;

    // Setup steps for one edge through the shared multiplier
    typedef enum logic [2:0] {
        PH_MUL_A,
        PH_MUL_B,
        PH_CONST,
        PH_ORIGIN_Y,
        PH_ORIGIN_X
    } phase_t;

    typedef struct packed {
        logic       load;
        logic       setup_en;
        logic [1:0] setup_edge;
        phase_t     setup_phase;
        logic       advance;
        logic       capture;
        logic       stage_empty;
        logic       set_found;
        logic       set_none;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic row_out;
        logic hit;
        logic active;
        logic out_free;
    } status_t;

endpackage

/* sv/tbr_if.sv */
// Handshake channels of the triangle block rasterizer: input items and result blocks.
// Depends on nothing; widths follow the item and result fields.
`timescale 1ns / 1ps

interface tbr_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [13:0] ax;
    logic [13:0] ay;
    logic [13:0] bx;
    logic [13:0] by_coord;
    logic [13:0] cx;
    logic [13:0] cy;
    logic [31:0] fill_color;

    modport source (output valid, action, ax, ay, bx, by_coord, cx, cy, fill_color,
                    input ready);
    modport sink (input valid, action, ax, ay, bx, by_coord, cx, cy, fill_color,
                  output ready);
endinterface

interface tbr_result_if;
    logic        valid;
    logic        ready;
    logic [9:0]  block_x;
    logic [9:0]  block_y;
    logic [63:0] coverage;
    logic [31:0] pixel_color;
    logic        last;

    modport source (output valid, block_x, block_y, coverage, pixel_color, last,
                    input ready);
    modport sink (input valid, block_x, block_y, coverage, pixel_color, last,
                  output ready);
endinterface

/* sv/tbr_ctrl.sv */
// Sequencer of the rasterizer: setup steps, block scan and result hand-off.
// Depends on tbr_pkg; drives tbr_datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps

module tbr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_action,
    output logic             item_ready,
    input  tbr_pkg::status_t status,
    output tbr_pkg::cmd_t    cmd
);
    import tbr_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] edge_reg, edge_next;
    phase_t     phase_reg, phase_next;
    logic       accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= 2'd0;
            phase_reg <= PH_MUL_A;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.setup_edge  = edge_reg;
        cmd.setup_phase = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_action == ACT_START)
                    begin
                        cmd.load   = 1'b1;
                        edge_next  = 2'd0;
                        phase_next = PH_MUL_A;
                        state_next = ST_SETUP;
                    end
                    else if (status.active)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.stage_empty = 1'b1;
                        cmd.set_none    = 1'b1;
                        state_next      = ST_FINISH;
                    end
                end
            end

            ST_SETUP:
            begin
                cmd.setup_en = 1'b1;
                unique case (phase_reg)
                    PH_MUL_A:    phase_next = PH_MUL_B;
                    PH_MUL_B:    phase_next = PH_CONST;
                    PH_CONST:    phase_next = PH_ORIGIN_Y;
                    PH_ORIGIN_Y: phase_next = PH_ORIGIN_X;
                    PH_ORIGIN_X:
                    begin
                        phase_next = PH_MUL_A;
                        if (edge_reg == 2'd2)
                        begin
                            edge_next  = 2'd0;
                            state_next = ST_SEARCH;
                        end
                        else
                        begin
                            edge_next = edge_reg + 2'd1;
                        end
                    end
                    default:     phase_next = PH_MUL_A;
                endcase
            end

            // Find the block to return
            ST_SEARCH:
            begin
                if (status.at_end)
                begin
                    cmd.stage_empty = 1'b1;
                    cmd.set_none    = 1'b1;
                    state_next      = ST_FINISH;
                end
                else if (!status.row_out && status.hit)
                begin
                    cmd.capture = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = ST_SEARCH_NEXT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end

            // Look ahead for the following covered block to set last
            ST_SEARCH_NEXT:
            begin
                if (status.at_end)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (!status.row_out && status.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    a_setup_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP && edge_reg == 2'd2 && phase_reg == PH_ORIGIN_X)
        |=> state_reg == ST_SEARCH)
        else $error("setup did not hand over to search");

    a_no_capture_outside_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == ST_SEARCH && cmd.advance))
        else $error("capture outside search");

    a_setup_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |-> edge_reg != 2'd3)
        else $error("setup edge index out of range");

endmodule

/* sv/tbr_datapath.sv */
// Datapath: vertex setup over a shared multiplier, block edge values, 8x8 coverage
// mask, staging and result register. Depends on tbr_pkg and tbr_result_if.
`timescale 1ns / 1ps

module tbr_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [13:0]               ax,
    input  logic [13:0]               ay,
    input  logic [13:0]               bx,
    input  logic [13:0]               by_coord,
    input  logic [13:0]               cx,
    input  logic [13:0]               cy,
    input  logic [31:0]               fill_color,
    input  tbr_pkg::cmd_t             cmd,
    output tbr_pkg::status_t          status,
    tbr_result_if.source              result
);
    import tbr_pkg::*;

    logic [COORD_W-1:0] vx_reg [3];
    logic [COORD_W-1:0] vy_reg [3];
    logic [COLOR_W-1:0] held_color_reg;

    logic signed [DELTA_W-1:0] edge_dx_reg [3];
    logic signed [DELTA_W-1:0] edge_dy_reg [3];
    logic signed [EDGE_W-1:0]  e_row_reg [3];
    logic signed [EDGE_W-1:0]  e_blk_reg [3];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [EDGE_W-1:0]  acc_reg;

    logic [POS_W-1:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic [POS_W-1:0] cursor_x_reg, cursor_y_reg;
    logic             active_reg;

    logic [POS_W-1:0]  stage_x_reg, stage_y_reg;
    logic [MASK_W-1:0] stage_mask_reg;
    logic              stage_last_reg;

    logic              out_valid_reg;
    logic [OUTPOS_W-1:0] out_x_reg, out_y_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic              out_last_reg;

    // Setup operand selection
    logic [COORD_W-1:0]        vx_e, vy_e, vx_n, vy_n;
    logic signed [DELTA_W-1:0] dx_s, dy_s;
    logic signed [DELTA_W-1:0] mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      bias;
    logic signed [EDGE_W-1:0]  e0;

    logic [COORD_W-1:0] min_vx, min_vy, max_vx, max_vy;
    logic [POS_W-1:0]   rmin_x, rmin_y, rmax_x, rmax_y;
    logic [COORD_W:0]   sum_min_x, sum_min_y, sum_max_x, sum_max_y;

    logic [MASK_W-1:0] mask;
    logic              step_right;

    always_comb
    begin
        unique case (cmd.setup_edge)
            2'd0:
            begin
                vx_e = vx_reg[0]; vy_e = vy_reg[0]; vx_n = vx_reg[1]; vy_n = vy_reg[1];
            end
            2'd1:
            begin
                vx_e = vx_reg[1]; vy_e = vy_reg[1]; vx_n = vx_reg[2]; vy_n = vy_reg[2];
            end
            default:
            begin
                vx_e = vx_reg[2]; vy_e = vy_reg[2]; vx_n = vx_reg[0]; vy_n = vy_reg[0];
            end
        endcase
        dx_s = $signed({1'b0, vx_e}) - $signed({1'b0, vx_n});
        dy_s = $signed({1'b0, vy_e}) - $signed({1'b0, vy_n});
        bias = (dy_s < 0) || (dy_s == 0 && dx_s > 0);
    end

    always_comb
    begin
        unique case (cmd.setup_phase)
            PH_MUL_A:
            begin
                mul_a = dy_s;
                mul_b = $signed({3'b0, vx_e});
            end
            PH_MUL_B:
            begin
                mul_a = dx_s;
                mul_b = $signed({3'b0, vy_e});
            end
            PH_CONST:
            begin
                mul_a = dx_s;
                mul_b = $signed({2'b0, box_min_y_reg, 4'b0});
            end
            PH_ORIGIN_Y:
            begin
                mul_a = dy_s;
                mul_b = $signed({2'b0, box_min_x_reg, 4'b0});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        e0    = acc_reg - EDGE_W'(prod_reg);
    end

    // Bounding box from the stored vertices
    always_comb
    begin
        min_vx = vx_reg[0];
        max_vx = vx_reg[0];
        min_vy = vy_reg[0];
        max_vy = vy_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx_reg[i] < min_vx) min_vx = vx_reg[i];
            if (vx_reg[i] > max_vx) max_vx = vx_reg[i];
            if (vy_reg[i] < min_vy) min_vy = vy_reg[i];
            if (vy_reg[i] > max_vy) max_vy = vy_reg[i];
        end
        sum_min_x = {1'b0, min_vx} + (COORD_W+1)'(ROUND_UP);
        sum_min_y = {1'b0, min_vy} + (COORD_W+1)'(ROUND_UP);
        sum_max_x = {1'b0, max_vx} + (COORD_W+1)'(ROUND_UP);
        sum_max_y = {1'b0, max_vy} + (COORD_W+1)'(ROUND_UP);
        rmin_x = {sum_min_x[COORD_W:SUBPIXEL_BITS+3], 3'b000};
        rmin_y = {sum_min_y[COORD_W:SUBPIXEL_BITS+3], 3'b000};
        rmax_x = sum_max_x[COORD_W:SUBPIXEL_BITS];
        rmax_y = sum_max_y[COORD_W:SUBPIXEL_BITS];
        if (rmax_x > POS_W'(SCREEN_PIXELS)) rmax_x = POS_W'(SCREEN_PIXELS);
        if (rmax_y > POS_W'(SCREEN_PIXELS)) rmax_y = POS_W'(SCREEN_PIXELS);
    end

    // Coverage of the block at the cursor: sample points step 16 in subpixels
    always_comb
    begin
        logic signed [EDGE_W-1:0] dx16, dy16, v;
        logic                     inside_all;
        mask = '0;
        for (int r = 0; r < BLOCK_SIZE; r++)
        begin
            for (int c = 0; c < BLOCK_SIZE; c++)
            begin
                inside_all = 1'b1;
                for (int e = 0; e < 3; e++)
                begin
                    dx16 = EDGE_W'(edge_dx_reg[e]) <<< SUBPIXEL_BITS;
                    dy16 = EDGE_W'(edge_dy_reg[e]) <<< SUBPIXEL_BITS;
                    v = e_blk_reg[e] + dx16 * EDGE_W'(r) - dy16 * EDGE_W'(c);
                    if (v <= 0) inside_all = 1'b0;
                end
                mask[r*BLOCK_SIZE + c] = inside_all;
            end
        end
    end

    assign step_right = ({1'b0, cursor_x_reg} + (POS_W+1)'(BLOCK_SIZE))
                        < {1'b0, box_max_x_reg};

    assign status.at_end   = cursor_y_reg >= box_max_y_reg;
    assign status.row_out  = cursor_x_reg >= box_max_x_reg;
    assign status.hit      = |mask;
    assign status.active   = active_reg;
    assign status.out_free = !out_valid_reg || result.ready;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg[0] <= ax;
            vy_reg[0] <= ay;
            vx_reg[1] <= bx;
            vy_reg[1] <= by_coord;
            vx_reg[2] <= cx;
            vy_reg[2] <= cy;
        end

        if (cmd.setup_en)
        begin
            prod_reg <= mul_p;
            unique case (cmd.setup_phase)
                PH_MUL_A:    acc_reg <= acc_reg;
                PH_MUL_B:    acc_reg <= EDGE_W'(prod_reg);
                PH_CONST:    acc_reg <= acc_reg - EDGE_W'(prod_reg) + EDGE_W'(bias);
                PH_ORIGIN_Y: acc_reg <= acc_reg + EDGE_W'(prod_reg);
                default:     acc_reg <= acc_reg;
            endcase
        end

        if (cmd.capture)
        begin
            stage_x_reg    <= cursor_x_reg;
            stage_y_reg    <= cursor_y_reg;
            stage_mask_reg <= mask;
        end
        else if (cmd.stage_empty)
        begin
            stage_x_reg    <= '0;
            stage_y_reg    <= '0;
            stage_mask_reg <= '0;
        end

        if (cmd.commit)
        begin
            out_x_reg     <= stage_x_reg[OUTPOS_W-1:0];
            out_y_reg     <= stage_y_reg[OUTPOS_W-1:0];
            out_mask_reg  <= stage_mask_reg;
            out_color_reg <= held_color_reg;
            out_last_reg  <= stage_last_reg;
        end
    end

    // Triangle state, cleared at reset; the staged last flag resets high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < 3; e++)
            begin
                edge_dx_reg[e] <= '0;
                edge_dy_reg[e] <= '0;
                e_row_reg[e]   <= '0;
                e_blk_reg[e]   <= '0;
            end
            box_min_x_reg  <= '0;
            box_min_y_reg  <= '0;
            box_max_x_reg  <= '0;
            box_max_y_reg  <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            active_reg     <= 1'b0;
            held_color_reg <= '0;
            stage_last_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                held_color_reg <= fill_color;
            end

            if (cmd.setup_en && cmd.setup_phase == PH_MUL_A && cmd.setup_edge == 2'd0)
            begin
                box_min_x_reg <= rmin_x;
                box_min_y_reg <= rmin_y;
                box_max_x_reg <= rmax_x;
                box_max_y_reg <= rmax_y;
                cursor_x_reg  <= rmin_x;
                cursor_y_reg  <= rmin_y;
            end

            if (cmd.setup_en && cmd.setup_phase == PH_ORIGIN_X)
            begin
                edge_dx_reg[cmd.setup_edge] <= dx_s;
                edge_dy_reg[cmd.setup_edge] <= dy_s;
                e_row_reg[cmd.setup_edge]   <= e0;
                e_blk_reg[cmd.setup_edge]   <= e0;
            end

            // Step one block right, or wrap to the next block row
            if (cmd.advance)
            begin
                if (step_right)
                begin
                    cursor_x_reg <= cursor_x_reg + POS_W'(BLOCK_SIZE);
                    for (int e = 0; e < 3; e++)
                    begin
                        e_blk_reg[e] <= e_blk_reg[e]
                                        - (EDGE_W'(edge_dy_reg[e]) <<< (SUBPIXEL_BITS + 3));
                    end
                end
                else
                begin
                    cursor_x_reg <= box_min_x_reg;
                    cursor_y_reg <= cursor_y_reg + POS_W'(BLOCK_SIZE);
                    for (int e = 0; e < 3; e++)
                    begin
                        e_row_reg[e] <= e_row_reg[e]
                                        + (EDGE_W'(edge_dx_reg[e]) <<< (SUBPIXEL_BITS + 3));
                        e_blk_reg[e] <= e_row_reg[e]
                                        + (EDGE_W'(edge_dx_reg[e]) <<< (SUBPIXEL_BITS + 3));
                    end
                end
            end

            if (cmd.set_found)
            begin
                active_reg     <= 1'b1;
                stage_last_reg <= 1'b0;
            end
            else if (cmd.set_none)
            begin
                active_reg     <= 1'b0;
                stage_last_reg <= 1'b1;
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.block_x     = out_x_reg;
    assign result.block_y     = out_y_reg;
    assign result.coverage    = out_mask_reg;
    assign result.pixel_color = out_color_reg;
    assign result.last        = out_last_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before transfer");

    a_cursor_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_x_reg[2:0] == 3'b000 && cursor_y_reg[2:0] == 3'b000)
        else $error("cursor off block grid");

    a_found_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_found |=> (active_reg && !stage_last_reg))
        else $error("lookahead hit not recorded");

endmodule

/* sv/triangle_block_rasterizer.sv */
// Half-space triangle rasterizer returning 8x8 pixel blocks with coverage masks.
// Start item: setup of each edge in steps on one shared multiplier, then a block
// by block scan to the first and the following covered block, then the hand-off.
// Next item: a block by block scan up to the following covered block, then the hand-off.
// One item in work at a time; a finished result waits in an output register.
// Reset (rst_n, async, active low) leaves no triangle: next items return empty, last.
`timescale 1ns / 1ps

module triangle_block_rasterizer (
    input  logic clk,
    input  logic rst_n,
    tbr_item_if.sink     item,
    tbr_result_if.source result
);
    import tbr_pkg::*;

    cmd_t    cmd;
    status_t status;

    tbr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .status      (status),
        .cmd         (cmd)
    );

    tbr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ax         (item.ax),
        .ay         (item.ay),
        .bx         (item.bx),
        .by_coord   (item.by_coord),
        .cx         (item.cx),
        .cy         (item.cy),
        .fill_color (item.fill_color),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

endmodule

/* tb/triangle_block_rasterizer_tb.sv */
// Self-checking testbench for triangle_block_rasterizer: directed rows, then random triangles.
// Depends on tbr_pkg, tbr_if and the rasterizer RTL; predicts every block in-line.
`timescale 1ns / 1ps

module triangle_block_rasterizer_tb;
    import tbr_pkg::*;

    localparam int NUM_ITEMS   = 1450;
    localparam int STALL_LIMIT = 200000;
    localparam int MAX_COORD   = 16383;

    typedef struct {
        logic        action;
        logic [13:0] ax, ay, bx, by_coord, cx, cy;
        logic [31:0] fill_color;
        bit          has_exp;
        logic [9:0]  exp_x, exp_y;
        logic [63:0] exp_cov;
        logic [31:0] exp_color;
        logic        exp_last;
    } tri_item_t;

    typedef struct {
        logic [9:0]  block_x, block_y;
        logic [63:0] coverage;
        logic [31:0] pixel_color;
        logic        last;
    } block_t;

    logic clk;
    logic rst_n;

    tbr_item_if   item ();
    tbr_result_if result ();

    triangle_block_rasterizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // rasterizer state mirror
    int          edx [3];
    int          edy [3];
    longint      econ [3];
    int          box_x0, box_x1, box_y0, box_y1;
    int          walk_x, walk_y;
    bit          tri_live;
    logic [31:0] tri_color;

    tri_item_t stim_q [$];
    block_t    block_q [$];
    int        fail_count;
    bit        calm;

    function automatic logic [63:0] cover_mask(int px, int py);
        logic [63:0] m;
        longint      sx, sy, v;
        bit          hit;
        m = '0;
        for (int r = 0; r < BLOCK_SIZE; r++)
        begin
            for (int c = 0; c < BLOCK_SIZE; c++)
            begin
                sx  = longint'(px + c) * 16;
                sy  = longint'(py + r) * 16;
                hit = 1'b1;
                for (int e = 0; e < 3; e++)
                begin
                    v = econ[e] + longint'(edx[e]) * sy - longint'(edy[e]) * sx;
                    if (v <= 0)
                        hit = 1'b0;
                end
                if (hit)
                    m[r * BLOCK_SIZE + c] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic bit seek_block(int sx, int sy, output int fx, output int fy);
        int x;
        fx = 0;
        fy = 0;
        for (int y = sy; y < box_y1; y += BLOCK_SIZE)
        begin
            x = (y == sy) ? sx : box_x0;
            for (; x < box_x1; x += BLOCK_SIZE)
            begin
                if (cover_mask(x, y) != 0)
                begin
                    fx = x;
                    fy = y;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic block_t rasterize_step(tri_item_t it);
        block_t b;
        int     vx [3];
        int     vy [3];
        int     n, nx, ny, lo, hi;
        b = '{default: '0};
        if (it.action == ACT_START)
        begin
            vx[0] = it.ax; vy[0] = it.ay;
            vx[1] = it.bx; vy[1] = it.by_coord;
            vx[2] = it.cx; vy[2] = it.cy;
            tri_color = it.fill_color;
            for (int e = 0; e < 3; e++)
            begin
                n = (e + 1) % 3;
                edx[e]  = vx[e] - vx[n];
                edy[e]  = vy[e] - vy[n];
                econ[e] = longint'(edy[e]) * vx[e] - longint'(edx[e]) * vy[e];
                // top-left fill rule
                if (edy[e] < 0 || (edy[e] == 0 && edx[e] > 0))
                    econ[e] += 1;
            end
            lo = vx[0]; hi = vx[0];
            for (int i = 1; i < 3; i++)
            begin
                if (vx[i] < lo) lo = vx[i];
                if (vx[i] > hi) hi = vx[i];
            end
            box_x0 = ((lo + ROUND_UP) >> SUBPIXEL_BITS) & ~(BLOCK_SIZE - 1);
            box_x1 = (hi + ROUND_UP) >> SUBPIXEL_BITS;
            lo = vy[0]; hi = vy[0];
            for (int i = 1; i < 3; i++)
            begin
                if (vy[i] < lo) lo = vy[i];
                if (vy[i] > hi) hi = vy[i];
            end
            box_y0 = ((lo + ROUND_UP) >> SUBPIXEL_BITS) & ~(BLOCK_SIZE - 1);
            box_y1 = (hi + ROUND_UP) >> SUBPIXEL_BITS;
            if (box_x1 > SCREEN_PIXELS) box_x1 = SCREEN_PIXELS;
            if (box_y1 > SCREEN_PIXELS) box_y1 = SCREEN_PIXELS;
            tri_live = seek_block(box_x0, box_y0, walk_x, walk_y);
        end
        if (tri_live)
        begin
            b.block_x  = walk_x[9:0];
            b.block_y  = walk_y[9:0];
            b.coverage = cover_mask(walk_x, walk_y);
            tri_live   = seek_block(walk_x + BLOCK_SIZE, walk_y, nx, ny);
            if (tri_live)
            begin
                walk_x = nx;
                walk_y = ny;
            end
        end
        b.pixel_color = tri_color;
        b.last        = !tri_live;
        return b;
    endfunction

    function automatic tri_item_t make_item(logic act, int ax, int ay, int bx, int by,
                                            int cx, int cy, logic [31:0] color);
        tri_item_t it;
        it = '{default: '0};
        it.action = act;
        it.ax = ax[13:0]; it.ay = ay[13:0];
        it.bx = bx[13:0]; it.by_coord = by[13:0];
        it.cx = cx[13:0]; it.cy = cy[13:0];
        it.fill_color = color;
        return it;
    endfunction

    function automatic tri_item_t with_exp(tri_item_t it, logic [31:0] color);
        it.has_exp   = 1'b1;
        it.exp_color = color;
        it.exp_last  = 1'b1;
        return it;
    endfunction

    function automatic int jitter(int base, int span);
        int v;
        v = base + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > MAX_COORD) v = MAX_COORD;
        return v;
    endfunction

    function automatic tri_item_t random_next();
        return make_item(ACT_NEXT, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                         $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                         $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                         $urandom);
    endfunction

    task automatic build_stimulus();
        int span, bx0, by0, walk;
        // no triangle yet: empty block, reset color
        stim_q.push_back(with_exp(make_item(ACT_NEXT, 0, 0, 0, 0, 0, 0, 32'h0), 32'h0));
        // degenerate triangles at both coordinate extremes
        stim_q.push_back(with_exp(make_item(ACT_START, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF),
                                  32'hFFFF_FFFF));
        stim_q.push_back(with_exp(make_item(ACT_START, MAX_COORD, MAX_COORD, MAX_COORD,
                                            MAX_COORD, MAX_COORD, MAX_COORD, 32'h0),
                                  32'h0));
        stim_q.push_back(with_exp(make_item(ACT_NEXT, 0, 0, 0, 0, 0, 0, 32'h1), 32'h0));
        // both windings of a small right triangle
        stim_q.push_back(make_item(ACT_START, 0, 0, 1600, 0, 0, 1600, 32'h1234_5678));
        repeat (3) stim_q.push_back(random_next());
        stim_q.push_back(make_item(ACT_START, 0, 0, 0, 1600, 1600, 0, 32'h8765_4321));
        repeat (3) stim_q.push_back(random_next());
        // edges exactly on sample points exercise the fill rule
        stim_q.push_back(make_item(ACT_START, 256, 256, 256, 768, 768, 256, 32'hA5A5_A5A5));
        stim_q.push_back(random_next());
        stim_q.push_back(make_item(ACT_START, 256, 256, 768, 256, 256, 768, 32'h5A5A_5A5A));
        stim_q.push_back(random_next());
        // full-screen triangles, both windings, abandoned mid-walk
        stim_q.push_back(make_item(ACT_START, 0, 0, MAX_COORD, 0, 0, MAX_COORD, 32'hC0FF_EE00));
        repeat (2) stim_q.push_back(random_next());
        stim_q.push_back(make_item(ACT_START, 0, 0, 0, MAX_COORD, MAX_COORD, 0, 32'h00EE_FF0C));
        repeat (2) stim_q.push_back(random_next());
        stim_q.push_back(make_item(ACT_START, MAX_COORD, MAX_COORD, MAX_COORD, 0,
                                   0, MAX_COORD, 32'h0F0F_0F0F));
        stim_q.push_back(random_next());

        while (stim_q.size() < NUM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                stim_q.push_back(random_next());
                continue;
            end
            case ($urandom_range(0, 99)) inside
                [0:79]:  span = 400;
                [80:96]: span = 3000;
                default: span = MAX_COORD;
            endcase
            bx0 = $urandom_range(0, MAX_COORD);
            by0 = $urandom_range(0, MAX_COORD);
            stim_q.push_back(make_item(ACT_START, jitter(bx0, span), jitter(by0, span),
                                       jitter(bx0, span), jitter(by0, span),
                                       jitter(bx0, span), jitter(by0, span), $urandom));
            walk = (span == MAX_COORD) ? $urandom_range(0, 3) : $urandom_range(0, 10);
            repeat (walk) stim_q.push_back(random_next());
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // predict on each input transfer, check on each result transfer
    always @(posedge clk)
    begin
        tri_item_t it;
        block_t    pred;
        block_t    want;
        if (rst_n && item.valid && item.ready)
        begin
            it.action = item.action;
            it.ax = item.ax; it.ay = item.ay;
            it.bx = item.bx; it.by_coord = item.by_coord;
            it.cx = item.cx; it.cy = item.cy;
            it.fill_color = item.fill_color;
            pred = rasterize_step(it);
            block_q.push_back(pred);
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (block_q.size() == 0)
            begin
                $error("unexpected result block at x=%0d y=%0d", result.block_x,
                       result.block_y);
                fail_count++;
            end
            else
            begin
                want = block_q.pop_front();
                check_field("block_x", want.block_x, result.block_x);
                check_field("block_y", want.block_y, result.block_y);
                check_field("coverage", want.coverage, result.coverage);
                check_field("pixel_color", want.pixel_color, result.pixel_color);
                check_field("last", want.last, result.last);
            end
        end
    end

    // typed expectations of directed rows, matched in order of acceptance
    tri_item_t typed_q [$];
    always @(posedge clk)
    begin
        tri_item_t t;
        if (rst_n && result.valid && result.ready && typed_q.size() != 0
            && typed_q[0].has_exp)
        begin
            t = typed_q.pop_front();
            check_field("block_x", t.exp_x, result.block_x);
            check_field("block_y", t.exp_y, result.block_y);
            check_field("coverage", t.exp_cov, result.coverage);
            check_field("pixel_color", t.exp_color, result.pixel_color);
            check_field("last", t.exp_last, result.last);
        end
        else if (rst_n && result.valid && result.ready && typed_q.size() != 0)
            void'(typed_q.pop_front());
    end

    // sink stalls in bursts
    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    int quiet_cycles;
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAIL triangle_block_rasterizer");
            $finish;
        end
    end

    initial
    begin
        tri_item_t it;
        int        total;
        fail_count = 0;
        calm       = 1'b0;
        stall_left = 0;
        rst_n      = 1'b0;
        item.valid = 1'b0;
        item.action = ACT_NEXT;
        item.ax = '0; item.ay = '0; item.bx = '0;
        item.by_coord = '0; item.cx = '0; item.cy = '0;
        item.fill_color = '0;
        result.ready = 1'b0;
        tri_live = 1'b0;
        tri_color = '0;
        for (int e = 0; e < 3; e++)
        begin
            edx[e] = 0; edy[e] = 0; econ[e] = 0;
        end
        box_x0 = 0; box_x1 = 0; box_y0 = 0; box_y1 = 0;
        walk_x = 0; walk_y = 0;
        build_stimulus();
        total = stim_q.size();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < total; i++)
        begin
            it = stim_q[i];
            if (i > total * 85 / 100)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                item.valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            item.valid      <= 1'b1;
            item.action     <= it.action;
            item.ax         <= it.ax;
            item.ay         <= it.ay;
            item.bx         <= it.bx;
            item.by_coord   <= it.by_coord;
            item.cx         <= it.cx;
            item.cy         <= it.cy;
            item.fill_color <= it.fill_color;
            typed_q.push_back(it);
            do
                @(posedge clk);
            while (!item.ready);
        end
        item.valid <= 1'b0;

        // let the last transfer reach the prediction queue
        @(posedge clk);
        while (block_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS triangle_block_rasterizer");
        else
            $display("FAIL triangle_block_rasterizer");
        $finish;
    end

endmodule
